// File: rtl/magma_pkg.sv
// magma_pkg: shared types, constants and the round function of the cipher
// used by magma_keys, magma_round and magma_block_cipher; no dependencies
package magma_pkg;

  localparam int WORD_W     = 32;
  localparam int KEY_WORDS  = 8;
  localparam int KEY_SEL_W  = $clog2(KEY_WORDS);
  localparam int ROUNDS     = 32;
  localparam int ROT        = 11;
  localparam int CFG_IDX_W  = 8;
  localparam int NIBBLES    = WORD_W / 4;

  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_set_t;

  typedef struct packed {
    logic valid;
    logic action;
  } magma_ctl_t;

  typedef logic [3:0] sbox_row_t [16];

  localparam sbox_row_t SBOX [NIBBLES] = '{
    '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
      4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
    '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
      4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
    '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
      4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
    '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
      4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
    '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
      4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
    '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
      4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
    '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
      4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
    '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
      4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
  };

  // add round key, substitute nibbles, rotate left
  function automatic word_t round_fn(input word_t half, input word_t rkey);
    word_t sum;
    word_t acc;
    sum = half + rkey;
    for (int n = 0; n < NIBBLES; n++) begin
      acc[4*n +: 4] = SBOX[n][sum[4*n +: 4]];
    end
    return {acc[WORD_W-ROT-1:0], acc[WORD_W-1:WORD_W-ROT]};
  endfunction

endpackage

// File: rtl/magma_keys.sv
// magma_keys: key word registers written through the configuration channel
// depends on magma_pkg
module magma_keys (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [magma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  magma_pkg::word_t               cfg_data,
  output magma_pkg::key_set_t            keys
);
  import magma_pkg::*;

  logic write_en;

  assign cfg_ready = 1'b1;
  assign write_en  = cfg_valid && cfg_ready &&
                     (cfg_index < CFG_IDX_W'(KEY_WORDS));

  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= '0;
    end else if (write_en) begin
      keys[cfg_index[KEY_SEL_W-1:0]] <= cfg_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    write_en |=> keys[$past(cfg_index[KEY_SEL_W-1:0])] == $past(cfg_data))
    else $error("key word not updated by config transaction");

endmodule

// File: rtl/magma_round.sv
// magma_round: one registered feistel round of the cipher pipeline
// depends on magma_pkg
module magma_round (
  input  logic                  clk,
  input  logic                  rst,
  input  magma_pkg::magma_ctl_t ctl_in,
  input  magma_pkg::word_t      n1_in,
  input  magma_pkg::word_t      n2_in,
  input  magma_pkg::word_t      rkey,
  output magma_pkg::magma_ctl_t ctl_out,
  output magma_pkg::word_t      n1_out,
  output magma_pkg::word_t      n2_out
);
  import magma_pkg::*;

  word_t t_next;

  assign t_next = n2_in ^ round_fn(n1_in, rkey);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.action <= ctl_in.action;
    n1_out         <= t_next;
    n2_out         <= n1_in;
  end

  assert property (@(posedge clk) disable iff (rst)
    ctl_out.valid |-> $past(ctl_in.valid))
    else $error("round stage valid without an entering transaction");

endmodule

// File: rtl/magma_block_cipher.sv
// magma_block_cipher: 32-round magma block cipher, one round per pipeline stage
// depends on magma_pkg, magma_keys and magma_round
//
// usage:
//   key words 0..7 are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
//   cfg_ready is always high and indexes above 7 are dropped. write keys only
//   while no block is in flight.
//   a block is taken when start is high and busy is low; action selects
//   encrypt (0) or decrypt (1). busy is only high during reset, so a new
//   block can be started on every cycle.
//   the result appears on block_out with done high for one cycle, once the
//   block has passed through the 32 unrolled round stages; throughput is one
//   block per cycle, each round stage being one add and s-box lookup deep.
//   reset clears all key words to zero and drops every block in flight.
//   the receiver cannot stall: results must be taken when done is high.
module magma_block_cipher (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action,
  input  logic [63:0]                     block_in,
  output logic                            done,
  output logic [63:0]                     block_out,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [magma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  magma_pkg::word_t                cfg_data
);
  import magma_pkg::*;

  key_set_t   keys;
  magma_ctl_t ctl [ROUNDS+1];
  word_t      n1  [ROUNDS+1];
  word_t      n2  [ROUNDS+1];
  word_t      rk  [ROUNDS];

  assign busy         = rst;
  assign ctl[0].valid  = start && !busy;
  assign ctl[0].action = action;
  assign n1[0]         = block_in[WORD_W-1:0];
  assign n2[0]         = block_in[2*WORD_W-1:WORD_W];

  magma_keys u_keys (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .keys      (keys)
  );

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam int POS = r % KEY_WORDS;

    // first eight rounds forward, last eight reversed, middle by action
    if (r < KEY_WORDS) begin : g_fwd
      assign rk[r] = keys[POS];
    end else if (r >= ROUNDS - KEY_WORDS) begin : g_rev
      assign rk[r] = keys[KEY_WORDS-1-POS];
    end else begin : g_sel
      assign rk[r] = (ctl[r].action == ACT_DECRYPT) ? keys[KEY_WORDS-1-POS]
                                                    : keys[POS];
    end

    magma_round u_round (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl[r]),
      .n1_in   (n1[r]),
      .n2_in   (n2[r]),
      .rkey    (rk[r]),
      .ctl_out (ctl[r+1]),
      .n1_out  (n1[r+1]),
      .n2_out  (n2[r+1])
    );
  end

  // last round keeps the halves unswapped
  assign done      = ctl[ROUNDS].valid;
  assign block_out = {n1[ROUNDS], n2[ROUNDS]};

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 32))
    else $error("result without a start transaction 32 cycles earlier");

endmodule
